/* rtl/vrs_pkg.sv */
package vrs_pkg;

  // Divider pipeline: the dividend magnitude is at most 2^32 scaled by 2^15.
  localparam int DvdW    = 48;
  localparam int DivBits = 4;
  localparam int NDiv    = DvdW / DivBits;
  localparam int DirW    = 16;
  localparam int VoxW    = 16;
  localparam int OrgW    = 32;
  localparam int ProdW   = OrgW + DirW;

  typedef enum logic [2:0] {
    FACE_TOP    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_NORTH  = 3'd2,
    FACE_SOUTH  = 3'd3,
    FACE_EAST   = 3'd4,
    FACE_WEST   = 3'd5
  } face_t;

  // One axis of the shared restoring divider.
  typedef struct packed {
    logic [DirW:0]   rem;
    logic [DvdW-1:0] rq;
    logic [DirW-1:0] ud;
    logic            neg;
    logic            nz;
  } div_t;

  typedef struct packed {
    logic [2:0][VoxW-1:0] vox;
    logic [2:0][OrgW-1:0] org;
    logic [2:0][DirW-1:0] dir;
  } pay_t;

  // Numerator magnitude, quotient sign and divisor magnitude for one axis.
  function automatic div_t div_prep(logic [VoxW-1:0] vox, logic [OrgW-1:0] org,
                                    logic [DirW-1:0] dir);
    div_t             d;
    logic             dpos;
    logic [VoxW+1:0]  bnd;
    logic [34:0]      num;
    logic [34:0]      mag;
    dpos  = !dir[DirW-1] && (dir != '0);
    bnd   = {{2{vox[VoxW-1]}}, vox} + {{(VoxW+1){1'b0}}, dpos};
    num   = {bnd[VoxW+1], bnd, 16'b0} - {{3{org[OrgW-1]}}, org};
    mag   = num[34] ? (~num + 35'd1) : num;
    d.rem = '0;
    d.rq  = {mag[32:0], 15'b0};
    d.ud  = dir[DirW-1] ? (~dir + 16'd1) : dir;
    d.neg = num[34] != dir[DirW-1];
    d.nz  = (dir != '0);
    return d;
  endfunction

  // DivBits steps of restoring division: dividend bits leave the top of rq,
  // quotient bits enter at its bottom.
  function automatic div_t div_step(div_t din);
    div_t          d;
    logic [DirW:0] r;
    d = din;
    for (int k = 0; k < DivBits; k++) begin
      r    = {d.rem[DirW-1:0], d.rq[DvdW-1]};
      d.rq = {d.rq[DvdW-2:0], 1'b0};
      if (r >= {1'b0, d.ud}) begin
        r       = r - {1'b0, d.ud};
        d.rq[0] = 1'b1;
      end
      d.rem = r;
    end
    return d;
  endfunction

  // Signed Q16.16 parameter from the quotient magnitude, saturating.
  function automatic logic [OrgW-1:0] div_sat(div_t d);
    logic [OrgW-1:0] t;
    if (d.neg) begin
      if (d.rq > 48'h0000_8000_0000) t = 32'h8000_0000;
      else                           t = ~d.rq[OrgW-1:0] + 32'd1;
    end else begin
      if (d.rq > 48'h0000_7FFF_FFFF) t = 32'h7FFF_FFFF;
      else                           t = d.rq[OrgW-1:0];
    end
    return t;
  endfunction

endpackage

/* rtl/vrs_ray_if.sv */
interface vrs_ray_if;
  import vrs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [VoxW-1:0] voxel_x;
  logic signed [VoxW-1:0] voxel_y;
  logic signed [VoxW-1:0] voxel_z;
  logic signed [OrgW-1:0] origin_x;
  logic signed [OrgW-1:0] origin_y;
  logic signed [OrgW-1:0] origin_z;
  logic signed [DirW-1:0] dir_x;
  logic signed [DirW-1:0] dir_y;
  logic signed [DirW-1:0] dir_z;

  modport source (output valid, voxel_x, voxel_y, voxel_z, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, voxel_x, voxel_y, voxel_z, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, output ready);
endinterface

/* rtl/vrs_res_if.sv */
interface vrs_res_if;
  import vrs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [VoxW-1:0] next_x;
  logic signed [VoxW-1:0] next_y;
  logic signed [VoxW-1:0] next_z;
  logic signed [OrgW-1:0] hit_x;
  logic signed [OrgW-1:0] hit_y;
  logic signed [OrgW-1:0] hit_z;
  logic [2:0]             face;
  logic                   no_direction;

  modport source (output valid, next_x, next_y, next_z, hit_x, hit_y, hit_z, face,
                  no_direction, input ready);
  modport sink (input valid, next_x, next_y, next_z, hit_x, hit_y, hit_z, face,
                no_direction, output ready);
endinterface

/* rtl/voxel_ray_step.sv */
// Channel | Dir | Contents
// ray     | in  | voxel_x/y/z, origin_x/y/z (Q16.16), dir_x/y/z (Q1.15)
// res     | out | next_x/y/z, hit_x/y/z (Q16.16), face, no_direction
//
// Every request gives one result; a new request can be accepted every cycle
// while ready is high. There is one prepare stage, then 12 divider stages of
// 4 quotient bits each, then saturate, compare, multiply and output stages.
// Reset clears only the stage valid bits. A stalled result holds in the output
// register; each stage still loads while it is empty, so bubbles close up and
// ready only drops once the pipe is full.
module voxel_ray_step (
  input logic      clk,
  input logic      rst,
  vrs_ray_if.sink  ray,
  vrs_res_if.source res
);
  import vrs_pkg::*;

  // Divider stage 0 is the prepare register; stages 1..NDiv each retire
  // DivBits quotient bits for all three axes.
  div_t [2:0] dv     [0:NDiv];
  pay_t       dpay   [0:NDiv];
  logic       dvld   [0:NDiv];
  logic       den    [0:NDiv];

  // Saturate stage: per-axis parameter.
  pay_t                 tpay;
  logic [2:0][OrgW-1:0] tt;
  logic [2:0]           tnz;
  logic                 tvld;
  logic                 ten;

  // Compare stage: chosen axis, stepped voxel and face.
  pay_t                 cpay;
  logic [OrgW-1:0]      ct;
  logic [2:0][VoxW-1:0] cnext;
  face_t                cface;
  logic                 cnodir;
  logic                 cvld;
  logic                 cen;

  // Multiply stage: t times each direction component.
  logic [2:0][OrgW-1:0]  morg;
  logic [2:0][ProdW-1:0] mprod;
  logic [2:0][VoxW-1:0]  mnext;
  face_t                 mface;
  logic                  mnodir;
  logic                  mvld;
  logic                  men;

  // Output register.
  logic [2:0][VoxW-1:0] onext;
  logic [2:0][OrgW-1:0] ohit;
  face_t                oface;
  logic                 onodir;
  logic                 ovld;
  logic                 oen;

  // A stage loads when it is empty or its content moves on this cycle.
  assign oen = !ovld || res.ready;
  assign men = !mvld || oen;
  assign cen = !cvld || men;
  assign ten = !tvld || cen;
  assign den[NDiv] = !dvld[NDiv] || ten;
  for (genvar k = 0; k < NDiv; k++) begin : g_en
    assign den[k] = !dvld[k] || den[k+1];
  end
  assign ray.ready = den[0];

  // Prepare stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (den[0]) begin
      dvld[0] <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (den[0]) begin
      dpay[0].vox <= {ray.voxel_z, ray.voxel_y, ray.voxel_x};
      dpay[0].org <= {ray.origin_z, ray.origin_y, ray.origin_x};
      dpay[0].dir <= {ray.dir_z, ray.dir_y, ray.dir_x};
      dv[0][0]    <= div_prep(ray.voxel_x, ray.origin_x, ray.dir_x);
      dv[0][1]    <= div_prep(ray.voxel_y, ray.origin_y, ray.dir_y);
      dv[0][2]    <= div_prep(ray.voxel_z, ray.origin_z, ray.dir_z);
    end
  end

  // Divider stages.
  for (genvar k = 1; k <= NDiv; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k] <= 1'b0;
      end else if (den[k]) begin
        dvld[k] <= dvld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (den[k]) begin
        dpay[k] <= dpay[k-1];
        for (int a = 0; a < 3; a++) begin
          dv[k][a] <= div_step(dv[k-1][a]);
        end
      end
    end
  end

  // Saturate stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tvld <= 1'b0;
    end else if (ten) begin
      tvld <= dvld[NDiv];
    end
  end

  always_ff @(posedge clk) begin
    if (ten) begin
      tpay <= dpay[NDiv];
      for (int a = 0; a < 3; a++) begin
        tt[a]  <= div_sat(dv[NDiv][a]);
        tnz[a] <= dv[NDiv][a].nz;
      end
    end
  end

  // Compare stage: a zero component always loses. Every compare is strict, so
  // x or y is only chosen when it is strictly smallest and ties go to the later
  // axis.
  logic       less01;
  logic       less02;
  logic       less12;
  logic [1:0] axis;
  logic       pos;
  logic [2:0][VoxW-1:0] next_next;
  face_t      face_next;

  always_comb begin
    less01 = tnz[0] && (!tnz[1] || ($signed(tt[0]) < $signed(tt[1])));
    less02 = tnz[0] && (!tnz[2] || ($signed(tt[0]) < $signed(tt[2])));
    less12 = tnz[1] && (!tnz[2] || ($signed(tt[1]) < $signed(tt[2])));
    if (less01 && less02) axis = 2'd0;
    else if (less12)      axis = 2'd1;
    else                  axis = 2'd2;
    pos       = !tpay.dir[axis][DirW-1];
    next_next = tpay.vox;
    next_next[axis] = tpay.vox[axis] + (pos ? 16'd1 : 16'hFFFF);
    unique case (axis)
      2'd0:    face_next = pos ? FACE_WEST : FACE_EAST;
      2'd1:    face_next = pos ? FACE_BOTTOM : FACE_TOP;
      default: face_next = pos ? FACE_SOUTH : FACE_NORTH;
    endcase
    if (tnz == 3'b000) begin
      next_next = '0;
      face_next = FACE_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld <= 1'b0;
    end else if (cen) begin
      cvld <= tvld;
    end
  end

  always_ff @(posedge clk) begin
    if (cen) begin
      cpay   <= tpay;
      ct     <= tt[axis];
      cnext  <= next_next;
      cface  <= face_next;
      cnodir <= (tnz == 3'b000);
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= 1'b0;
    end else if (men) begin
      mvld <= cvld;
    end
  end

  always_ff @(posedge clk) begin
    if (men) begin
      morg   <= cpay.org;
      mnext  <= cnext;
      mface  <= cface;
      mnodir <= cnodir;
      for (int a = 0; a < 3; a++) begin
        mprod[a] <= ProdW'($signed(ct) * $signed(cpay.dir[a]));
      end
    end
  end

  // Output stage: floor by 2^15, add the origin, saturate.
  logic [2:0][OrgW-1:0] hit_next;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [ProdW-1:0] sum;
      sum = ProdW'($signed(mprod[a]) >>> 15) + {{DirW{morg[a][OrgW-1]}}, morg[a]};
      if (mnodir) begin
        hit_next[a] = morg[a];
      end else if ($signed(sum) > $signed(48'sh0000_7FFF_FFFF)) begin
        hit_next[a] = 32'h7FFF_FFFF;
      end else if ($signed(sum) < $signed(48'shFFFF_8000_0000)) begin
        hit_next[a] = 32'h8000_0000;
      end else begin
        hit_next[a] = sum[OrgW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (oen) begin
      ovld <= mvld;
    end
  end

  always_ff @(posedge clk) begin
    if (oen) begin
      onext  <= mnext;
      ohit   <= hit_next;
      oface  <= mface;
      onodir <= mnodir;
    end
  end

  assign res.valid        = ovld;
  assign res.next_x       = onext[0];
  assign res.next_y       = onext[1];
  assign res.next_z       = onext[2];
  assign res.hit_x        = ohit[0];
  assign res.hit_y        = ohit[1];
  assign res.hit_z        = ohit[2];
  assign res.face         = oface;
  assign res.no_direction = onodir;

  // The x-axis divider remainder stays below its divisor whenever that axis is live.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dvld[NDiv] && dv[NDiv][0].nz |-> dv[NDiv][0].rem < {1'b0, dv[NDiv][0].ud})
    else $error("divider remainder out of range");

  // A result with no direction is voxel zero entered through the top.
  a_nodir: assert property (@(posedge clk) disable iff (rst)
    ovld && onodir |-> (oface == FACE_TOP) && (onext == '0))
    else $error("no-direction result malformed");

  // A stalled compare stage keeps its chosen parameter.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cvld && !cen |=> cvld && $stable(ct) && $stable(cface))
    else $error("compare stage lost data on stall");

  // Input is refused only while stage 0, the last divider stage and every later stage are full.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !ray.ready |-> dvld[0] && dvld[NDiv] && tvld && cvld && mvld && ovld)
    else $error("input refused with a free stage");

endmodule

/* tb/voxel_ray_step_tb.sv */
module voxel_ray_step_tb;
  import vrs_pkg::*;

  // A request as the sender drives it; the predicted result uses the same
  // layout as the result channel.
  typedef struct {
    logic signed [15:0] vx, vy, vz;
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_req_t;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic signed [31:0] hx, hy, hz;
    logic [2:0]         face;
    logic               nodir;
  } step_res_t;

  // One row of the directed table: the request, and a typed-in result where
  // one can be read off at a glance.
  typedef struct {
    ray_req_t  req;
    logic      has_res;
    step_res_t res;
  } dir_row_t;

  localparam int Latency  = 17;
  localparam int Watchdog = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  vrs_ray_if ray ();
  vrs_res_if res ();

  voxel_ray_step uut (
    .clk(clk),
    .rst(rst),
    .ray(ray.sink),
    .res(res.source)
  );

  step_res_t pending_steps[$];
  int        errors = 0;
  int        sent = 0;
  int        received = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Ray parameter of one axis: the distance in t to the next boundary in the
  // direction of travel, exact over wide integers and truncated toward zero.
  // A zero component marks the axis as never reaching a boundary.
  function automatic longint boundary_t(input longint vox, input longint org,
                                        input longint d, output bit live);
    longint num, q;
    live = (d != 0);
    if (!live) return 64'sd2147483647;
    num = ((vox + (d > 0 ? 1 : 0)) * 65536 - org) * 32768;
    q = num / d;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Origin plus t times the component, floored, then saturated to 32 bits.
  function automatic logic signed [31:0] hit_at(input longint org, input longint t,
                                                input longint d);
    longint p, s;
    p = t * d;
    s = (p >= 0) ? (p >>> 15) : -((-p + 32767) >>> 15);
    s = org + s;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // An axis beats another only if it is live and either the other is dead or
  // its t is strictly smaller; with that strictness the chain below hands ties
  // to the later axis.
  function automatic bit beats(input bit la, input longint ta, input bit lb,
                               input longint tb);
    if (!la) return 1'b0;
    if (!lb) return 1'b1;
    return ta < tb;
  endfunction

  function automatic step_res_t predict_step(input ray_req_t r);
    step_res_t o;
    longint    vox[3], org[3], dir[3], t[3];
    bit        live[3];
    int        axis;
    bit        pos;
    vox = '{r.vx, r.vy, r.vz};
    org = '{r.ox, r.oy, r.oz};
    dir = '{r.dx, r.dy, r.dz};
    for (int i = 0; i < 3; i++) t[i] = boundary_t(vox[i], org[i], dir[i], live[i]);
    if (beats(live[0], t[0], live[1], t[1]) && beats(live[0], t[0], live[2], t[2]))
      axis = 0;
    else if (beats(live[1], t[1], live[2], t[2]))
      axis = 1;
    else if (live[2])
      axis = 2;
    else
      axis = -1;
    o.nx = r.vx;
    o.ny = r.vy;
    o.nz = r.vz;
    o.hx = r.ox;
    o.hy = r.oy;
    o.hz = r.oz;
    o.nodir = 1'b0;
    if (axis < 0) begin
      // No direction at all: zero voxel, hit at the origin, top face.
      o.nx = '0;
      o.ny = '0;
      o.nz = '0;
      o.face = FACE_TOP;
      o.nodir = 1'b1;
    end else begin
      pos = dir[axis] > 0;
      o.hx = hit_at(org[0], t[axis], dir[0]);
      o.hy = hit_at(org[1], t[axis], dir[1]);
      o.hz = hit_at(org[2], t[axis], dir[2]);
      case (axis)
        0: begin
          o.nx = r.vx + (pos ? 16'sd1 : -16'sd1);
          o.face = pos ? FACE_WEST : FACE_EAST;
        end
        1: begin
          o.ny = r.vy + (pos ? 16'sd1 : -16'sd1);
          o.face = pos ? FACE_BOTTOM : FACE_TOP;
        end
        default: begin
          o.nz = r.vz + (pos ? 16'sd1 : -16'sd1);
          o.face = pos ? FACE_SOUTH : FACE_NORTH;
        end
      endcase
    end
    return o;
  endfunction

  function automatic ray_req_t mk_req(input int vx, input int vy, input int vz,
                                      input int ox, input int oy, input int oz,
                                      input int dx, input int dy, input int dz);
    ray_req_t r;
    r.vx = 16'(vx);
    r.vy = 16'(vy);
    r.vz = 16'(vz);
    r.ox = ox;
    r.oy = oy;
    r.oz = oz;
    r.dx = 16'(dx);
    r.dy = 16'(dy);
    r.dz = 16'(dz);
    return r;
  endfunction

  // Random ray. Mostly a well-formed ray: an origin inside or near its voxel,
  // with small voxels so the hit point does not always saturate. The rest is
  // raw noise over the full field ranges, and some zeroed components.
  function automatic ray_req_t rand_req();
    ray_req_t r;
    int       mode;
    mode = $urandom_range(0, 9);
    r.vx = 16'($urandom);
    r.vy = 16'($urandom);
    r.vz = 16'($urandom);
    r.ox = $urandom;
    r.oy = $urandom;
    r.oz = $urandom;
    r.dx = 16'($urandom);
    r.dy = 16'($urandom);
    r.dz = 16'($urandom);
    if (mode < 7) begin
      r.vx = 16'($signed($urandom_range(0, 255)) - 128);
      r.vy = 16'($signed($urandom_range(0, 255)) - 128);
      r.vz = 16'($signed($urandom_range(0, 255)) - 128);
      r.ox = {r.vx, 16'h0} + $signed($urandom_range(0, 32'h1_ffff)) - 32'sh8000;
      r.oy = {r.vy, 16'h0} + $signed($urandom_range(0, 32'h1_ffff)) - 32'sh8000;
      r.oz = {r.vz, 16'h0} + $signed($urandom_range(0, 32'h1_ffff)) - 32'sh8000;
      if ($urandom_range(0, 3) == 0) r.dy = r.dx;
    end
    if (mode == 8 || $urandom_range(0, 7) == 0) r.dx = '0;
    if ($urandom_range(0, 7) == 0) r.dy = '0;
    if ($urandom_range(0, 7) == 0) r.dz = '0;
    if ($urandom_range(0, 31) == 0) begin
      r.dx = 16'($urandom_range(0, 3) - 1);
      r.dy = '0;
    end
    return r;
  endfunction

  dir_row_t directed_rows[$];

  // The table: extremes of every field, each face, ties, zero components
  // beside a saturating axis, negative parameters and the all-zero direction.
  task automatic build_table();
    dir_row_t  row;
    step_res_t zero_dir;
    zero_dir = '{nx: 0, ny: 0, nz: 0, hx: 0, hy: 0, hz: 0, face: FACE_TOP, nodir: 1'b1};
    row.has_res = 1'b1;
    row.req = mk_req(5, -7, 9, 0, 0, 0, 0, 0, 0);
    row.res = zero_dir;
    directed_rows.push_back(row);
    row.req = mk_req(32767, -32768, 1, 32'h7fffffff, 32'h80000000, 1234, 0, 0, 0);
    row.res = zero_dir;
    row.res.hx = 32'h7fffffff;
    row.res.hy = 32'h80000000;
    row.res.hz = 1234;
    directed_rows.push_back(row);
    row.has_res = 1'b0;
    row.res = zero_dir;
    // One axis per face, from the center of voxel (0,0,0).
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 16384, 0, 0);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, -16384, 0, 0);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 0, 16384, 0);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 0, -16384, 0);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 0, 0, 16384);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 0, 0, -16384);
    directed_rows.push_back(row);
    // Three-way and two-way ties.
    row.req = mk_req(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 9000, 9000, 9000);
    directed_rows.push_back(row);
    row.req = mk_req(3, 3, 3, 32'h38000, 32'h38000, 32'h38000, 100, -9000, -9000);
    directed_rows.push_back(row);
    // Tiny components make t saturate, yet the live axis still wins.
    row.req = mk_req(-32768, 0, 0, 32'h7fffffff, 0, 0, 1, 0, 0);
    directed_rows.push_back(row);
    row.req = mk_req(32767, 32767, 0, 32'h80000000, 32'h80000000, 0, -1, 1, 0);
    directed_rows.push_back(row);
    // Origin outside its voxel gives a negative parameter.
    row.req = mk_req(0, 0, 0, 32'h50000, 0, 0, 32767, 0, 0);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, -32'sh50000, 0, 0, -32768, 20000, -5);
    directed_rows.push_back(row);
    // Wrapping of the stepped voxel and saturation of the hit point.
    row.req = mk_req(32767, 0, 0, 32'h7fff8000, 32'h7fffffff, 32'h80000000,
                     32767, 32767, -32768);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, -32768, 0, 32'h7fffffff, 32'h80000000, 1, -32768, -32768);
    directed_rows.push_back(row);
    row.req = mk_req(-1, -1, -1, 32'hffffffff, 32'hffffffff, 32'hffffffff, -1, -1, -1);
    directed_rows.push_back(row);
    row.req = mk_req(0, 0, 0, 0, 0, 0, 32767, 32767, 32767);
    directed_rows.push_back(row);
  endtask

  task automatic compare_step(input step_res_t exp_r);
    if (res.next_x !== exp_r.nx) begin
      $error("next_x: expected %0d, got %0d", exp_r.nx, res.next_x);
      errors++;
    end
    if (res.next_y !== exp_r.ny) begin
      $error("next_y: expected %0d, got %0d", exp_r.ny, res.next_y);
      errors++;
    end
    if (res.next_z !== exp_r.nz) begin
      $error("next_z: expected %0d, got %0d", exp_r.nz, res.next_z);
      errors++;
    end
    if (res.hit_x !== exp_r.hx) begin
      $error("hit_x: expected %0d, got %0d", exp_r.hx, res.hit_x);
      errors++;
    end
    if (res.hit_y !== exp_r.hy) begin
      $error("hit_y: expected %0d, got %0d", exp_r.hy, res.hit_y);
      errors++;
    end
    if (res.hit_z !== exp_r.hz) begin
      $error("hit_z: expected %0d, got %0d", exp_r.hz, res.hit_z);
      errors++;
    end
    if (res.face !== exp_r.face) begin
      $error("face: expected %0d, got %0d", exp_r.face, res.face);
      errors++;
    end
    if (res.no_direction !== exp_r.nodir) begin
      $error("no_direction: expected %0d, got %0d", exp_r.nodir, res.no_direction);
      errors++;
    end
  endtask

  // Result side: ready is redrawn at each falling edge, and every result
  // accepted at a rising edge is checked against the oldest prediction.
  initial res.ready = 1'b0;

  always @(negedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      received++;
      if (pending_steps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        compare_step(pending_steps.pop_front());
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((ray.valid && ray.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("watchdog: no traffic for %0d cycles", Watchdog);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one request from the falling edge and hold it until accepted. The
  // sender may idle first with valid low; valid is then raised for the request,
  // and the caller lowers it when the stream pauses.
  task automatic send_ray(input ray_req_t r, input step_res_t exp_r, input bit typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      ray.valid <= 1'b0;
      @(negedge clk);
    end
    ray.valid <= 1'b1;
    ray.voxel_x <= r.vx;
    ray.voxel_y <= r.vy;
    ray.voxel_z <= r.vz;
    ray.origin_x <= r.ox;
    ray.origin_y <= r.oy;
    ray.origin_z <= r.oz;
    ray.dir_x <= r.dx;
    ray.dir_y <= r.dy;
    ray.dir_z <= r.dz;
    do @(posedge clk); while (!ray.ready);
    // The prediction enters the queue at the accepting edge, before any result
    // of it can come out.
    pending_steps.push_back(typed ? exp_r : predict_step(r));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    ray.valid <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk);
  endtask

  initial begin
    int phase_send[4];
    int phase_recv[4];
    ray.valid = 1'b0;
    ray.voxel_x = '0;
    ray.voxel_y = '0;
    ray.voxel_z = '0;
    ray.origin_x = '0;
    ray.origin_y = '0;
    ray.origin_z = '0;
    ray.dir_x = '0;
    ray.dir_y = '0;
    ray.dir_z = '0;
    phase_send = '{0, 81, 0, 28};
    phase_recv = '{0, 0, 81, 28};
    build_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows run back to back with no idling on either side.
    foreach (directed_rows[i])
      send_ray(directed_rows[i].req, directed_rows[i].res, directed_rows[i].has_res);
    // Hold the sender until the pipe has emptied once.
    drain_results();

    // Random rays in four idling phases, about 1700 in all.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (int n = 0; n < 425; n++) begin
        // Short stretches with no sender idling fall inside every phase.
        if (n % 100 < 15) send_idle_pct = 0;
        else send_idle_pct = phase_send[ph];
        send_ray(rand_req(), '{default: 0}, 1'b0);
      end
      drain_results();
    end
    recv_stall_pct = 0;
    repeat (Latency + 4) @(negedge clk);

    $display("Sent %0d rays (directed faces, ties, saturation, zero direction, random)",
             sent);
    $display("and checked %0d results under four idling and stall patterns.", received);
    if (errors == 0 && pending_steps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_steps.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
